>>> rtl/ftds_pkg.sv
// Package for the false target delay-sum block: payload structs, register codes,
// reset values, sequencer states and the control group of the shared MAC.
// No dependencies.
`default_nettype none

package ftds_pkg;

    localparam int SMP_W      = 16;
    localparam int WGT_W      = 16;
    localparam int DLY_W      = 13;
    localparam int PROD_W     = 2 * SMP_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int ACC_W      = 36;
    localparam int FRAC_W     = 14;
    localparam int OUT_W      = 20;
    localparam int LANE_W     = 3;
    localparam int LANE_IX_W  = 2;
    localparam int STEP_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int LEN_REG_W  = 14;
    localparam int CNT_REG_W  = 3;
    localparam int DLY_REG_W  = 52;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAYS       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_REAL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT_IMAG  = 3'd4;

    localparam logic [LEN_REG_W-1:0]  RST_WINDOW_LEN   = 14'd6666;
    localparam logic [CNT_REG_W-1:0]  RST_TARGET_COUNT = 3'd1;
    localparam logic [DLY_REG_W-1:0]  RST_DELAYS       = 52'd3298937585670;
    localparam logic [CFG_DATA_W-1:0] RST_WEIGHT_REAL  = 64'h4000_4000_4000_4000;
    localparam logic [CFG_DATA_W-1:0] RST_WEIGHT_IMAG  = 64'h0;

    // MAC steps of one lane
    localparam logic [STEP_W-1:0] MS_IWR   = 3'd0;
    localparam logic [STEP_W-1:0] MS_QWI   = 3'd1;
    localparam logic [STEP_W-1:0] MS_IWI   = 3'd2;
    localparam logic [STEP_W-1:0] MS_QWR   = 3'd3;
    localparam logic [STEP_W-1:0] MS_DRAIN = 3'd4;

    typedef struct packed {
        logic signed [SMP_W-1:0] in_i;
        logic signed [SMP_W-1:0] in_q;
    } t_in;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_i;
        logic signed [OUT_W-1:0] out_q;
        logic                    window_last;
        logic                    clipped;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_WRITE,
        ST_READ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic mul_en;
        logic sel_q;
        logic sel_wi;
        logic acc_clr;
        logic acc_en;
        logic acc_im;
        logic acc_sub;
    } t_mac_ctrl;

endpackage

`default_nettype wire

>>> rtl/ftds_mac.sv
// Shared complex multiply-accumulate unit: one 16x16 multiplier with a
// registered product feeding a real and an imaginary accumulator.
// Depends on ftds_pkg.
`default_nettype none

module ftds_mac (
    input  wire logic                                i_clk,
    input  wire ftds_pkg::t_mac_ctrl                 i_ctrl,
    input  wire ftds_pkg::t_in                       i_smp,
    input  wire logic signed [ftds_pkg::WGT_W-1:0]   i_wr,
    input  wire logic signed [ftds_pkg::WGT_W-1:0]   i_wi,
    output logic signed [ftds_pkg::SUM_W-1:0]        o_acc_re,
    output logic signed [ftds_pkg::SUM_W-1:0]        o_acc_im
);

    logic signed [ftds_pkg::SMP_W-1:0]  op_a;
    logic signed [ftds_pkg::WGT_W-1:0]  op_b;
    logic signed [ftds_pkg::PROD_W-1:0] prod;
    logic signed [ftds_pkg::PROD_W-1:0] r_prod;
    logic signed [ftds_pkg::SUM_W-1:0]  term;
    logic signed [ftds_pkg::SUM_W-1:0]  r_acc_re;
    logic signed [ftds_pkg::SUM_W-1:0]  r_acc_im;
    logic signed [ftds_pkg::SUM_W-1:0]  n_acc_re;
    logic signed [ftds_pkg::SUM_W-1:0]  n_acc_im;

    always_comb begin
        op_a = i_ctrl.sel_q ? i_smp.in_q : i_smp.in_i;
        op_b = i_ctrl.sel_wi ? i_wi : i_wr;
        prod = op_a * op_b;
        term = i_ctrl.acc_sub ? -ftds_pkg::SUM_W'(r_prod) : ftds_pkg::SUM_W'(r_prod);
        n_acc_re = r_acc_re;
        n_acc_im = r_acc_im;
        if (i_ctrl.acc_clr) begin
            n_acc_re = '0;
            n_acc_im = '0;
        end else if (i_ctrl.acc_en) begin
            if (i_ctrl.acc_im) begin
                n_acc_im = r_acc_im + term;
            end else begin
                n_acc_re = r_acc_re + term;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= prod;
        end
        r_acc_re <= n_acc_re;
        r_acc_im <= n_acc_im;
    end

    assign o_acc_re = r_acc_re;
    assign o_acc_im = r_acc_im;

endmodule

`default_nettype wire

>>> rtl/false_target_delay_sum.sv
// Top level of the false target delay-sum block: sequencer, accumulation
// store and output register. Depends on ftds_pkg and ftds_mac.
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  in       | i_in_valid, o_in_ready, i_in (t_in)      | sink
//  out      | o_out_valid, i_out_ready, o_out (t_out)  | source
//  cfg      | i_cfg_valid, o_cfg_ready, i_cfg_index,   | sink
//           | i_cfg_data                               |
//
// For each item, each active lane runs four products
// through the one shared multiplier, then a read-modify-write of the store.
// The store has one write and one registered read port.
// After reset a clearing pass writes zero to every store entry before the first item.
// The same pass runs at a window wrap after window_len was written, and before
// an item that finds the position beyond a shortened window.
// A result waiting in the output register stalls only the final cycle of the
// next item; configuration writes are always taken.
`default_nettype none

module false_target_delay_sum #(
    parameter int MAX_WINDOW  = 8192,
    parameter int NUM_TARGETS = 4
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_ready,
    input  wire ftds_pkg::t_in                         i_in,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output ftds_pkg::t_out                             o_out,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [ftds_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [ftds_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int AW   = $clog2(MAX_WINDOW);
    localparam int SW   = ((AW > ftds_pkg::DLY_W) ? AW : ftds_pkg::DLY_W) + 1;
    localparam int MW   = 2 * ftds_pkg::ACC_W;
    localparam int SHW  = ftds_pkg::ACC_W - ftds_pkg::FRAC_W;
    localparam int OW   = ftds_pkg::OUT_W;

    ftds_pkg::t_state                   r_state, n_state;
    logic [ftds_pkg::STEP_W-1:0]        r_step, n_step;
    logic [ftds_pkg::LANE_W-1:0]        r_lane, n_lane;
    logic [AW-1:0]                      r_pos, n_pos;
    logic [AW-1:0]                      r_clr, n_clr;
    logic                               r_dirty, n_dirty;
    logic                               r_resume, n_resume;
    logic                               r_out_valid, n_out_valid;

    logic [ftds_pkg::LEN_REG_W-1:0]     r_cfg_len;
    logic [ftds_pkg::CNT_REG_W-1:0]     r_cfg_count;
    logic [ftds_pkg::DLY_REG_W-1:0]     r_cfg_delays;
    logic [ftds_pkg::CFG_DATA_W-1:0]    r_cfg_wr;
    logic [ftds_pkg::CFG_DATA_W-1:0]    r_cfg_wi;

    ftds_pkg::t_in                      r_in;
    ftds_pkg::t_out                     r_out, n_out;
    logic [MW-1:0]                      r_mem [MAX_WINDOW];
    logic [MW-1:0]                      r_rd;

    logic                               mem_we;
    logic [AW-1:0]                      mem_wa;
    logic [MW-1:0]                      mem_wd;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic                               out_load;
    logic                               in_fire;
    logic                               out_take;
    logic                               out_free;
    logic                               cfg_fire;

    logic [SW-1:0]                      wl;
    logic [SW-1:0]                      len;
    logic [ftds_pkg::LANE_W-1:0]        lanes;
    logic [ftds_pkg::LANE_IX_W-1:0]     lane_ix;
    logic [ftds_pkg::DLY_W-1:0]         delay;
    logic signed [ftds_pkg::WGT_W-1:0]  wr;
    logic signed [ftds_pkg::WGT_W-1:0]  wi;
    logic [SW-1:0]                      pos_ext;
    logic [SW-1:0]                      idx;
    logic                               idx_ok;
    logic                               last;

    ftds_pkg::t_mac_ctrl                mac_ctrl;
    logic signed [ftds_pkg::SUM_W-1:0]  acc_re;
    logic signed [ftds_pkg::SUM_W-1:0]  acc_im;
    logic signed [ftds_pkg::ACC_W-1:0]  rd_re;
    logic signed [ftds_pkg::ACC_W-1:0]  rd_im;
    logic signed [ftds_pkg::ACC_W-1:0]  new_re;
    logic signed [ftds_pkg::ACC_W-1:0]  new_im;
    logic signed [SHW-1:0]              sh_re;
    logic signed [SHW-1:0]              sh_im;
    logic                               ovf_re;
    logic                               ovf_im;

    ftds_mac u_mac (
        .i_clk    (i_clk),
        .i_ctrl   (mac_ctrl),
        .i_smp    (r_in),
        .i_wr     (wr),
        .i_wi     (wi),
        .o_acc_re (acc_re),
        .o_acc_im (acc_im)
    );

    // Datapath around the store
    always_comb begin
        wl  = SW'(r_cfg_len);
        if (wl == '0) begin
            len = SW'(1);
        end else if (wl > SW'(MAX_WINDOW)) begin
            len = SW'(MAX_WINDOW);
        end else begin
            len = wl;
        end
        lanes   = (r_cfg_count > ftds_pkg::LANE_W'(NUM_TARGETS)) ?
                  ftds_pkg::LANE_W'(NUM_TARGETS) : r_cfg_count;
        lane_ix = r_lane[ftds_pkg::LANE_IX_W-1:0];
        delay   = r_cfg_delays[lane_ix * ftds_pkg::DLY_W +: ftds_pkg::DLY_W];
        wr      = r_cfg_wr[lane_ix * ftds_pkg::WGT_W +: ftds_pkg::WGT_W];
        wi      = r_cfg_wi[lane_ix * ftds_pkg::WGT_W +: ftds_pkg::WGT_W];
        pos_ext = SW'(r_pos);
        idx     = pos_ext + SW'(delay);
        idx_ok  = idx < len;
        last    = (pos_ext + SW'(1)) == len;

        rd_re   = r_rd[ftds_pkg::ACC_W-1:0];
        rd_im   = r_rd[MW-1:ftds_pkg::ACC_W];
        new_re  = rd_re + ftds_pkg::ACC_W'(acc_re);
        new_im  = rd_im + ftds_pkg::ACC_W'(acc_im);

        // floor shift, then saturate when the top bits disagree
        sh_re   = rd_re[ftds_pkg::ACC_W-1:ftds_pkg::FRAC_W];
        sh_im   = rd_im[ftds_pkg::ACC_W-1:ftds_pkg::FRAC_W];
        ovf_re  = !((&sh_re[SHW-1:OW-1]) || !(|sh_re[SHW-1:OW-1]));
        ovf_im  = !((&sh_im[SHW-1:OW-1]) || !(|sh_im[SHW-1:OW-1]));
        n_out.out_i = ovf_re ? (sh_re[SHW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}})
                             : sh_re[OW-1:0];
        n_out.out_q = ovf_im ? (sh_im[SHW-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}})
                             : sh_im[OW-1:0];
        n_out.window_last = last;
        n_out.clipped     = ovf_re || ovf_im;
    end

    assign in_fire     = i_in_valid && o_in_ready;
    assign out_take    = r_out_valid && i_out_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_lane     = r_lane;
        n_pos      = r_pos;
        n_clr      = r_clr;
        n_dirty    = r_dirty;
        n_resume   = r_resume;
        mem_we     = 1'b0;
        mem_wa     = '0;
        mem_wd     = '0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        out_load   = 1'b0;
        o_in_ready = 1'b0;
        mac_ctrl   = '0;

        case (r_state)
            ftds_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                n_clr  = r_clr + AW'(1);
                if (r_clr == AW'(MAX_WINDOW - 1)) begin
                    n_clr   = '0;
                    n_dirty = 1'b0;
                    n_step  = ftds_pkg::MS_IWR;
                    n_lane  = '0;
                    if (r_resume) begin
                        n_state = (lanes == '0) ? ftds_pkg::ST_READ : ftds_pkg::ST_MUL;
                    end else begin
                        n_state = ftds_pkg::ST_IDLE;
                    end
                end
            end
            ftds_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_step = ftds_pkg::MS_IWR;
                    n_lane = '0;
                    if (pos_ext >= len) begin
                        // window was shortened under the position: restart it
                        n_pos    = '0;
                        n_resume = 1'b1;
                        n_state  = ftds_pkg::ST_CLEAR;
                    end else begin
                        n_state = (lanes == '0) ? ftds_pkg::ST_READ : ftds_pkg::ST_MUL;
                    end
                end
            end
            ftds_pkg::ST_MUL: begin
                n_step = r_step + ftds_pkg::STEP_W'(1);
                case (r_step)
                    ftds_pkg::MS_IWR: begin
                        mac_ctrl.mul_en  = 1'b1;
                        mac_ctrl.acc_clr = 1'b1;
                        rd_en            = 1'b1;
                        rd_addr          = idx[AW-1:0];
                    end
                    ftds_pkg::MS_QWI: begin
                        mac_ctrl.mul_en = 1'b1;
                        mac_ctrl.sel_q  = 1'b1;
                        mac_ctrl.sel_wi = 1'b1;
                        mac_ctrl.acc_en = 1'b1;
                    end
                    ftds_pkg::MS_IWI: begin
                        mac_ctrl.mul_en  = 1'b1;
                        mac_ctrl.sel_wi  = 1'b1;
                        mac_ctrl.acc_en  = 1'b1;
                        mac_ctrl.acc_sub = 1'b1;
                    end
                    ftds_pkg::MS_QWR: begin
                        mac_ctrl.mul_en = 1'b1;
                        mac_ctrl.sel_q  = 1'b1;
                        mac_ctrl.acc_en = 1'b1;
                        mac_ctrl.acc_im = 1'b1;
                    end
                    ftds_pkg::MS_DRAIN: begin
                        mac_ctrl.acc_en = 1'b1;
                        mac_ctrl.acc_im = 1'b1;
                        n_state         = ftds_pkg::ST_WRITE;
                    end
                    default: begin
                        n_state = ftds_pkg::ST_WRITE;
                    end
                endcase
            end
            ftds_pkg::ST_WRITE: begin
                mem_we = idx_ok;
                mem_wa = idx[AW-1:0];
                mem_wd = {new_im, new_re};
                n_lane = r_lane + ftds_pkg::LANE_W'(1);
                n_step = ftds_pkg::MS_IWR;
                if ((r_lane + ftds_pkg::LANE_W'(1)) == lanes) begin
                    n_state = ftds_pkg::ST_READ;
                end else begin
                    n_state = ftds_pkg::ST_MUL;
                end
            end
            ftds_pkg::ST_READ: begin
                rd_en   = 1'b1;
                rd_addr = r_pos;
                n_state = ftds_pkg::ST_OUT;
            end
            ftds_pkg::ST_OUT: begin
                // hold until the output register can take the item
                if (out_free) begin
                    out_load = 1'b1;
                    mem_we   = 1'b1;
                    mem_wa   = r_pos;
                    if (last) begin
                        n_pos = '0;
                        if (r_dirty) begin
                            n_resume = 1'b0;
                            n_state  = ftds_pkg::ST_CLEAR;
                        end else begin
                            n_state = ftds_pkg::ST_IDLE;
                        end
                    end else begin
                        n_pos   = r_pos + AW'(1);
                        n_state = ftds_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ftds_pkg::ST_IDLE;
            end
        endcase

        // entries past a new window length must be swept at the next wrap
        if (cfg_fire && (i_cfg_index == ftds_pkg::CFG_WINDOW_LEN)) begin
            n_dirty = 1'b1;
        end

        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ftds_pkg::ST_CLEAR;
            r_step       <= ftds_pkg::MS_IWR;
            r_lane       <= '0;
            r_pos        <= '0;
            r_clr        <= '0;
            r_dirty      <= 1'b0;
            r_resume     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cfg_len    <= ftds_pkg::RST_WINDOW_LEN;
            r_cfg_count  <= ftds_pkg::RST_TARGET_COUNT;
            r_cfg_delays <= ftds_pkg::RST_DELAYS;
            r_cfg_wr     <= ftds_pkg::RST_WEIGHT_REAL;
            r_cfg_wi     <= ftds_pkg::RST_WEIGHT_IMAG;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_lane      <= n_lane;
            r_pos       <= n_pos;
            r_clr       <= n_clr;
            r_dirty     <= n_dirty;
            r_resume    <= n_resume;
            r_out_valid <= n_out_valid;
            if (cfg_fire) begin
                case (i_cfg_index)
                    ftds_pkg::CFG_WINDOW_LEN:
                        r_cfg_len <= i_cfg_data[ftds_pkg::LEN_REG_W-1:0];
                    ftds_pkg::CFG_TARGET_COUNT:
                        r_cfg_count <= i_cfg_data[ftds_pkg::CNT_REG_W-1:0];
                    ftds_pkg::CFG_DELAYS:
                        r_cfg_delays <= i_cfg_data[ftds_pkg::DLY_REG_W-1:0];
                    ftds_pkg::CFG_WEIGHT_REAL:
                        r_cfg_wr <= i_cfg_data;
                    ftds_pkg::CFG_WEIGHT_IMAG:
                        r_cfg_wi <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_in;
        end
        if (out_load) begin
            r_out <= n_out;
        end
    end

    // Accumulation store: {imag, real} per entry
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready)
        else $error("input accepted twice in a row");

    a_lane_inside_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ftds_pkg::ST_WRITE) |-> (pos_ext < len))
        else $error("lane update with position outside the window");

    a_wrap_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && last) |=> (r_pos == '0))
        else $error("position did not wrap after the last item of the window");

endmodule

`default_nettype wire
